### design/ssem_pkg.sv
// ----------------------------------------------------------------------------
// ssem_pkg
// Shared types and constants for the small experimental machine core:
// command and function codes, sequencer states and adder operations.
// ----------------------------------------------------------------------------
package ssem_pkg;

    localparam int WORD_BITS   = 32;
    localparam int STORE_DEPTH = 32;
    localparam int LINE_BITS   = $clog2(STORE_DEPTH);
    localparam int FUNC_LSB    = 13;
    localparam int FUNC_BITS   = 3;
    localparam int CMD_BITS    = 2;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [LINE_BITS-1:0] t_line;

    // request commands
    typedef enum logic [CMD_BITS-1:0] {
        CMD_STEP  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // instruction function field
    typedef enum logic [FUNC_BITS-1:0] {
        FN_JMP  = 3'd0,
        FN_JRP  = 3'd1,
        FN_LDN  = 3'd2,
        FN_STO  = 3'd3,
        FN_SUB  = 3'd4,
        FN_SUB2 = 3'd5,
        FN_CMP  = 3'd6,
        FN_STP  = 3'd7
    } t_func;

    // shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // adder request from the sequencer
    typedef struct packed {
        t_alu_op op;
        t_word   a;
        t_word   b;
    } t_alu_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

### design/small_experimental_machine_core_top.sv
// ----------------------------------------------------------------------------
// small_experimental_machine_core_top
// 32-line, 32-bit stored-program machine core. A small sequencer drives one
// shared adder and a single-port store through fetch, operand read and
// execute for each step request.
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+--------------
//  request   | i_cmd, i_line_address, i_write_word            | start / busy
//  result    | o_control_count, o_accumulator_value,          | o_done strobe
//            | o_read_word, o_executed_opcode, o_halted       |
//
// A request is taken when start is high and busy is low. After acceptance a
// step runs increment, fetch, decode, execute and done; a read or write runs
// its store access and done; a clear or a halted step goes straight to done.
// The store has a single port. The result shows for the one cycle o_done is
// high and the receiver cannot stall it. i_rst_n clears the counter,
// accumulator, halt flag and sequencer; the store keeps no reset value.
// ----------------------------------------------------------------------------
module small_experimental_machine_core_top
    import ssem_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [CMD_BITS-1:0]         i_cmd,
    input  logic [LINE_BITS-1:0]        i_line_address,
    input  logic [WORD_BITS-1:0]        i_write_word,
    output logic                        o_done,
    output logic [WORD_BITS-1:0]        o_control_count,
    output logic signed [WORD_BITS-1:0] o_accumulator_value,
    output logic [WORD_BITS-1:0]        o_read_word,
    output logic [FUNC_BITS-1:0]        o_executed_opcode,
    output logic                        o_halted
);

    t_state r_state, n_state;
    t_word  r_cc, n_cc;
    t_word  r_acc, n_acc;
    logic   r_halt, n_halt;
    t_cmd   r_cmd, n_cmd;
    t_line  r_addr, n_addr;
    t_word  r_wword, n_wword;
    t_word  r_rword, n_rword;
    t_func  r_op, n_op;
    t_word  r_instr, n_instr;

    // store and its single port
    t_word  r_store [STORE_DEPTH];
    t_word  r_rdata;
    t_line  mem_addr;
    logic   mem_we;
    t_word  mem_wdata;

    t_alu_req alu_req;
    t_word    alu_y;
    t_func    exec_func;
    t_line    exec_line;

    ssem_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_y)
    );

    assign exec_func = t_func'(r_instr[FUNC_LSB +: FUNC_BITS]);
    assign exec_line = r_instr[LINE_BITS-1:0];

    // store: one optional write and one registered read per cycle, same address
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_store[mem_addr];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cc    <= '0;
            r_acc   <= '0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cc    <= n_cc;
            r_acc   <= n_acc;
            r_halt  <= n_halt;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_addr  <= n_addr;
        r_wword <= n_wword;
        r_rword <= n_rword;
        r_op    <= n_op;
        r_instr <= n_instr;
    end

    // sequencer: next state, adder and store control
    always_comb begin
        n_state   = r_state;
        n_cc      = r_cc;
        n_acc     = r_acc;
        n_halt    = r_halt;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_wword   = r_wword;
        n_rword   = r_rword;
        n_op      = r_op;
        n_instr   = r_instr;
        mem_addr  = r_addr;
        mem_we    = 1'b0;
        mem_wdata = r_wword;
        alu_req   = '{op: ALU_ADD, a: '0, b: '0};

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_addr  = i_line_address;
                    n_wword = i_write_word;
                    n_rword = '0;
                    n_op    = FN_JMP;
                    unique case (t_cmd'(i_cmd))
                        CMD_STEP:  n_state = r_halt ? ST_DONE : ST_INC;
                        CMD_WRITE: n_state = ST_WRITE;
                        CMD_READ:  n_state = ST_READ;
                        CMD_CLEAR: begin
                            n_cc    = '0;
                            n_acc   = '0;
                            n_halt  = 1'b0;
                            n_state = ST_DONE;
                        end
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            // counter plus one
            ST_INC: begin
                alu_req = '{op: ALU_ADD, a: r_cc, b: t_word'(1)};
                n_cc    = alu_y;
                n_state = ST_FETCH;
            end
            // instruction read at the counter line
            ST_FETCH: begin
                mem_addr = r_cc[LINE_BITS-1:0];
                n_state  = ST_DECODE;
            end
            // latch instruction, read its operand line
            ST_DECODE: begin
                n_instr  = r_rdata;
                mem_addr = r_rdata[LINE_BITS-1:0];
                n_state  = ST_EXEC;
            end
            // execute with the operand in r_rdata
            ST_EXEC: begin
                n_op     = exec_func;
                mem_addr = exec_line;
                unique case (exec_func)
                    FN_JMP: begin
                        alu_req = '{op: ALU_ADD, a: '0, b: r_rdata};
                        n_cc    = alu_y;
                    end
                    FN_JRP: begin
                        alu_req = '{op: ALU_ADD, a: r_cc, b: r_rdata};
                        n_cc    = alu_y;
                    end
                    FN_LDN: begin
                        alu_req = '{op: ALU_SUB, a: '0, b: r_rdata};
                        n_acc   = alu_y;
                    end
                    FN_STO: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_acc;
                    end
                    FN_SUB, FN_SUB2: begin
                        alu_req = '{op: ALU_SUB, a: r_acc, b: r_rdata};
                        n_acc   = alu_y;
                    end
                    FN_CMP: begin
                        // skip the next line when the accumulator is negative
                        alu_req = '{op: ALU_ADD, a: r_cc,
                                    b: {{(WORD_BITS-1){1'b0}}, r_acc[WORD_BITS-1]}};
                        n_cc    = alu_y;
                    end
                    FN_STP: n_halt = 1'b1;
                    default: n_halt = r_halt;
                endcase
                n_state = ST_DONE;
            end
            ST_WRITE: begin
                mem_we  = 1'b1;
                n_state = ST_DONE;
            end
            // read issued here, data lands next cycle
            ST_READ: begin
                mem_addr = r_addr;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // read data is valid in the done cycle that follows the read
    always_comb begin
        if (r_cmd == CMD_READ) begin
            o_read_word = r_rdata;
        end else begin
            o_read_word = r_rword;
        end
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_done              = (r_state == ST_DONE);
    assign o_control_count     = r_cc;
    assign o_accumulator_value = $signed(r_acc);
    assign o_executed_opcode   = r_op;
    assign o_halted            = r_halt;

endmodule

### design/ssem_alu.sv
// ----------------------------------------------------------------------------
// ssem_alu
// Shared 32-bit add/subtract unit used by every arithmetic step of the core:
// counter increment, jump, relative jump, skip, negate-load and subtract.
// ----------------------------------------------------------------------------
module ssem_alu
    import ssem_pkg::*;
(
    input  t_alu_req i_req,
    output t_word    o_result
);

    // wrapping add or subtract
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: o_result = i_req.a + i_req.b;
            ALU_SUB: o_result = i_req.a - i_req.b;
            default: o_result = i_req.a;
        endcase
    end

endmodule

### tb/small_experimental_machine_core_top_tb.sv
// ----------------------------------------------------------------------------
// small_experimental_machine_core_top_tb
// Self-checking bench for the stored-program machine core. Requests go in on
// the start/busy handshake with random gaps. A behavioral model of the
// machine predicts every result. Each o_done strobe is checked field by field
// against the oldest prediction. A short directed program runs first, then
// many random programs with reads, writes and clears mixed in.
// ----------------------------------------------------------------------------
module small_experimental_machine_core_top_tb;
    import ssem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int DRAIN_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 20;

    // one machine result as seen on the output ports
    typedef struct {
        t_word          count;
        t_word          acc;
        t_word          rdata;
        logic [2:0]     opcode;
        logic           halted;
    } t_machine_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [CMD_BITS-1:0]         i_cmd;
    logic [LINE_BITS-1:0]        i_line_address;
    logic [WORD_BITS-1:0]        i_write_word;
    logic                        o_done;
    logic [WORD_BITS-1:0]        o_control_count;
    logic signed [WORD_BITS-1:0] o_accumulator_value;
    logic [WORD_BITS-1:0]        o_read_word;
    logic [FUNC_BITS-1:0]        o_executed_opcode;
    logic                        o_halted;

    // machine model state
    t_word model_store [STORE_DEPTH];
    t_word model_count;
    t_word model_acc;
    logic  model_halt;

    t_machine_result pending_results[$];
    int              failures;
    int              items_done;
    bit              no_gaps;

    small_experimental_machine_core_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cmd               (i_cmd),
        .i_line_address      (i_line_address),
        .i_write_word        (i_write_word),
        .o_done              (o_done),
        .o_control_count     (o_control_count),
        .o_accumulator_value (o_accumulator_value),
        .o_read_word         (o_read_word),
        .o_executed_opcode   (o_executed_opcode),
        .o_halted            (o_halted)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // instruction word with a given function and operand line
    function automatic t_word make_instr(t_func fn, t_line ln);
        t_word w;
        w = '0;
        w[FUNC_LSB +: FUNC_BITS] = fn;
        w[LINE_BITS-1:0] = ln;
        return w;
    endfunction

    // random store word, mostly instructions with a rare halt
    function automatic t_word random_word();
        t_word w;
        w = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 11) == 0)
                w[FUNC_LSB +: FUNC_BITS] = FN_STP;
            else
                w[FUNC_LSB +: FUNC_BITS] = $urandom_range(0, 6);
        end
        return w;
    endfunction

    // idle cycles before a request: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // advance the machine model by one request and return its result
    function automatic t_machine_result machine_next(t_cmd cmd, t_line addr, t_word wdata);
        t_machine_result r;
        t_word           instr;
        t_word           opnd;
        t_line           opl;
        t_func           fn;
        r.rdata  = '0;
        r.opcode = FN_JMP;
        case (cmd)
            CMD_STEP: begin
                if (!model_halt) begin
                    model_count = model_count + 1;
                    instr = model_store[model_count[LINE_BITS-1:0]];
                    opl   = instr[LINE_BITS-1:0];
                    fn    = t_func'(instr[FUNC_LSB +: FUNC_BITS]);
                    opnd  = model_store[opl];
                    case (fn)
                        FN_JMP:  model_count = opnd;
                        FN_JRP:  model_count = model_count + opnd;
                        FN_LDN:  model_acc = '0 - opnd;
                        FN_STO:  model_store[opl] = model_acc;
                        FN_SUB,
                        FN_SUB2: model_acc = model_acc - opnd;
                        FN_CMP: begin
                            if (model_acc[WORD_BITS-1])
                                model_count = model_count + 1;
                        end
                        default: model_halt = 1'b1;
                    endcase
                    r.opcode = fn;
                end
            end
            CMD_WRITE: model_store[addr] = wdata;
            CMD_READ:  r.rdata = model_store[addr];
            default: begin
                model_count = '0;
                model_acc   = '0;
                model_halt  = 1'b0;
            end
        endcase
        r.count  = model_count;
        r.acc    = model_acc;
        r.halted = model_halt;
        return r;
    endfunction

    // issue one request and record its expected result once accepted
    task automatic send_request(input t_cmd cmd, input t_line addr, input t_word wdata);
        int   gap;
        logic ignored;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_line_address <= addr;
        i_write_word   <= wdata;
        do @(posedge i_clk); while (busy);
        ignored = (cmd == CMD_STEP) && model_halt;
        pending_results.push_back(machine_next(cmd, addr, wdata));
        if (!ignored)
            items_done++;
    endtask

    // one mismatch report
    task automatic check_field(input string name, input t_word exp_v, input t_word act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            failures++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_machine_result e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
            end else begin
                e = pending_results.pop_front();
                check_field("control_count", e.count, o_control_count);
                check_field("accumulator_value", e.acc, o_accumulator_value);
                check_field("read_word", e.rdata, o_read_word);
                check_field("executed_opcode", t_word'(e.opcode), t_word'(o_executed_opcode));
                check_field("halted", t_word'(e.halted), t_word'(o_halted));
            end
        end
    end

    // directed program through every function but halt
    task automatic test_function_codes();
        send_request(CMD_WRITE, 5'd20, 32'h8000_0000);
        send_request(CMD_WRITE, 5'd21, 32'hFFFF_FFFF);
        send_request(CMD_WRITE, 5'd22, 32'h0000_0001);
        send_request(CMD_WRITE, 5'd23, 32'h0000_0000);
        send_request(CMD_WRITE, 5'd24, 32'h0000_0002);
        send_request(CMD_WRITE, 5'd25, 32'h0000_000F);
        send_request(CMD_WRITE, 5'd1,  make_instr(FN_LDN, 5'd20));
        send_request(CMD_WRITE, 5'd2,  make_instr(FN_SUB, 5'd21));
        send_request(CMD_WRITE, 5'd3,  make_instr(FN_SUB2, 5'd22));
        send_request(CMD_WRITE, 5'd4,  make_instr(FN_STO, 5'd23));
        send_request(CMD_WRITE, 5'd5,  make_instr(FN_CMP, 5'd20));
        send_request(CMD_WRITE, 5'd6,  make_instr(FN_STP, 5'd20));
        send_request(CMD_WRITE, 5'd7,  make_instr(FN_JRP, 5'd24));
        send_request(CMD_WRITE, 5'd10, make_instr(FN_JMP, 5'd25));
        send_request(CMD_WRITE, 5'd16, make_instr(FN_STP, 5'd20));
        // ldn, sub, second sub code, sto, cmp skipping line 6, jrp, jmp
        repeat (7) send_request(CMD_STEP, '0, '0);
    endtask

    // halt, step while halted, clear keeping the store
    task automatic test_halt_and_clear();
        send_request(CMD_STEP, '0, '0);
        send_request(CMD_STEP, 5'd31, 32'hFFFF_FFFF);
        send_request(CMD_READ, 5'd23, '0);
        send_request(CMD_CLEAR, '0, '0);
        send_request(CMD_STEP, '0, '0);
    endtask

    // random programs with random content, plus stray reads, writes, clears
    task automatic test_random_programs();
        int n;
        int steps;
        int r;
        for (int i = 0; i < STORE_DEPTH; i++)
            send_request(CMD_WRITE, t_line'(i), random_word());
        while (items_done < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 8);
            repeat (n) send_request(CMD_WRITE, t_line'($urandom), random_word());
            if ($urandom_range(0, 2) != 0)
                send_request(CMD_CLEAR, t_line'($urandom), $urandom);
            steps = $urandom_range(5, 40);
            for (int s = 0; s < steps; s++) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    send_request(CMD_READ, t_line'($urandom), $urandom);
                else if (r == 1)
                    send_request(CMD_WRITE, t_line'($urandom), random_word());
                else if (r == 2)
                    send_request(CMD_CLEAR, t_line'($urandom), $urandom);
                else
                    send_request(CMD_STEP, t_line'($urandom), $urandom);
                if (model_halt) begin
                    if ($urandom_range(0, 3) == 0)
                        send_request(CMD_STEP, t_line'($urandom), $urandom);
                    break;
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // main sequence
    initial begin
        int waited;
        failures       = 0;
        items_done     = 0;
        no_gaps        = 1'b0;
        model_count    = '0;
        model_acc      = '0;
        model_halt     = 1'b0;
        foreach (model_store[i]) model_store[i] = '0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_cmd          <= CMD_STEP;
        i_line_address <= '0;
        i_write_word   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_function_codes();
        test_halt_and_clear();
        test_random_programs();

        // drain outstanding results
        start  <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            failures++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("small_experimental_machine_core_top_tb OK");
        else
            $display("small_experimental_machine_core_top_tb NOT OK");
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("small_experimental_machine_core_top_tb NOT OK");
        $finish;
    end

endmodule
